### sv/http_settings_request_classifier_macros.svh
// Assertion macros shared by the request classifier RTL.
// No dependencies; bodies compile away when SYNTHESIS is defined.
`ifndef HTTP_SETTINGS_REQUEST_CLASSIFIER_MACROS_SVH
`define HTTP_SETTINGS_REQUEST_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define HSRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define HSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HSRC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/hsrc_pkg.sv
// Types, character constants and lookup functions for the request classifier.
// No dependencies.
package hsrc_pkg;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_Q   = 8'h3F;

  localparam logic [3:0] PATH_LEN = 4'd9;
  localparam logic [3:0] GET_LEN  = 4'd3;
  localparam logic [3:0] HEAD_LEN = 4'd4;
  localparam logic [3:0] POS_MAX  = 4'd15;

  localparam logic [2:0] PH_METHOD = 3'd0;
  localparam logic [2:0] PH_PATH   = 3'd1;
  localparam logic [2:0] PH_DONE   = 3'd2;

  localparam logic [1:0] CLS_INCOMPLETE = 2'd0;
  localparam logic [1:0] CLS_OTHER      = 2'd1;
  localparam logic [1:0] CLS_GET        = 2'd2;
  localparam logic [1:0] CLS_HEAD       = 2'd3;
  localparam logic [1:0] VERDICT_NONE   = 2'd0;

  localparam logic [1:0] BLM_NONE    = 2'd0;
  localparam logic [1:0] BLM_CR      = 2'd1;
  localparam logic [1:0] BLM_CRLF    = 2'd2;
  localparam logic [1:0] BLM_CRLFCR  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } stage_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] request_class;
  } result_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] path_char(input logic [3:0] pos);
    logic [7:0] r;
    unique case (pos)
      4'd0: r = 8'h2F;
      4'd1: r = 8'h73;
      4'd2: r = 8'h65;
      4'd3: r = 8'h74;
      4'd4: r = 8'h74;
      4'd5: r = 8'h69;
      4'd6: r = 8'h6E;
      4'd7: r = 8'h67;
      4'd8: r = 8'h73;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] get_char(input logic [3:0] pos);
    logic [7:0] r;
    unique case (pos)
      4'd0: r = 8'h47;
      4'd1: r = 8'h45;
      4'd2: r = 8'h54;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] head_char(input logic [3:0] pos);
    logic [7:0] r;
    unique case (pos)
      4'd0: r = 8'h48;
      4'd1: r = 8'h45;
      4'd2: r = 8'h41;
      4'd3: r = 8'h44;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

### sv/hsrc_byte_if.sv
// Byte channel into the classifier: valid, ready and one request byte.
// No dependencies.
interface hsrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/hsrc_class_if.sv
// Result channel out of the classifier: valid, ready and the request class.
// No dependencies.
interface hsrc_class_if;
  logic       valid;
  logic       ready;
  logic [1:0] request_class;

  modport source (output valid, output request_class, input ready);
  modport sink (input valid, input request_class, output ready);
endinterface

### sv/hsrc_in_stage.sv
// Input register of the classifier: holds one byte item until the core takes it.
// Depends on hsrc_pkg.
module hsrc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  hsrc_pkg::byte_item_t in_item_i,
  output logic               in_ready_o,
  input  logic               advance_i,
  output hsrc_pkg::stage_t   stage_o
);
  import hsrc_pkg::*;

  logic       valid_q, valid_d;
  byte_item_t item_q;
  logic       load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;
endmodule

### sv/hsrc_core.sv
// Classifier state: blank-line detector and request-line matcher, one byte a cycle
// (a final byte waits while the result register is full). Depends on hsrc_pkg.
module hsrc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsrc_pkg::stage_t stage_i,
  input  logic             out_free_i,
  output logic             advance_o,
  output hsrc_pkg::result_t res_o
);
  import hsrc_pkg::*;

  logic [1:0] blm_q, blm_d;
  logic       hdone_q, hdone_d;
  logic [2:0] phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic       getp_q, getp_d;
  logic       headp_q, headp_d;
  logic [1:0] verdict_q, verdict_d;
  logic [1:0] cls;

  assign advance_o = stage_i.valid && (!stage_i.item.last_byte || out_free_i);

  always_comb begin
    logic [7:0] c;
    logic [7:0] u;
    logic       g_sp;
    logic       h_sp;
    c         = stage_i.item.data_byte;
    u         = to_upper(c);
    g_sp      = getp_q && (pos_q == GET_LEN);
    h_sp      = headp_q && (pos_q == HEAD_LEN);
    blm_d     = blm_q;
    hdone_d   = hdone_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    getp_d    = getp_q;
    headp_d   = headp_q;
    verdict_d = verdict_q;
    cls       = CLS_INCOMPLETE;

    if (advance_o) begin
      priority if (c == CH_CR) begin
        blm_d = (blm_q == BLM_CRLF) ? BLM_CRLFCR : BLM_CR;
      end else if (c == CH_LF) begin
        if (blm_q == BLM_CR) begin
          blm_d = BLM_CRLF;
        end else begin
          if (blm_q == BLM_CRLFCR) begin
            hdone_d = 1'b1;
          end
          blm_d = BLM_NONE;
        end
      end else begin
        blm_d = BLM_NONE;
      end

      if (phase_q == PH_METHOD) begin
        priority if (c == CH_SP) begin
          getp_d  = g_sp;
          headp_d = h_sp;
          if (!g_sp && !h_sp) begin
            verdict_d = CLS_OTHER;
            phase_d   = PH_DONE;
          end else begin
            phase_d = PH_PATH;
            pos_d   = '0;
          end
        end else if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
          verdict_d = CLS_OTHER;
          phase_d   = PH_DONE;
        end else begin
          if (pos_q >= GET_LEN || u != get_char(pos_q)) begin
            getp_d = 1'b0;
          end
          if (pos_q >= HEAD_LEN || u != head_char(pos_q)) begin
            headp_d = 1'b0;
          end
          if (pos_q < POS_MAX) begin
            pos_d = pos_q + 4'd1;
          end
        end
      end else if (phase_q == PH_PATH) begin
        if (pos_q < PATH_LEN) begin
          if (c == path_char(pos_q)) begin
            pos_d = pos_q + 4'd1;
          end else begin
            verdict_d = CLS_OTHER;
            phase_d   = PH_DONE;
          end
        end else begin
          if (c == CH_SP || c == CH_Q || c == CH_CR || c == CH_LF || c == CH_NUL) begin
            priority if (headp_q) begin
              verdict_d = CLS_HEAD;
            end else if (getp_q) begin
              verdict_d = CLS_GET;
            end else begin
              verdict_d = CLS_OTHER;
            end
          end else begin
            verdict_d = CLS_OTHER;
          end
          phase_d = PH_DONE;
        end
      end

      if (stage_i.item.last_byte) begin
        priority if (!hdone_d) begin
          cls = CLS_INCOMPLETE;
        end else if (verdict_d == VERDICT_NONE) begin
          cls = CLS_OTHER;
        end else begin
          cls = verdict_d;
        end
        blm_d     = BLM_NONE;
        hdone_d   = 1'b0;
        phase_d   = PH_METHOD;
        pos_d     = '0;
        getp_d    = 1'b1;
        headp_d   = 1'b1;
        verdict_d = VERDICT_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blm_q     <= BLM_NONE;
      hdone_q   <= 1'b0;
      phase_q   <= PH_METHOD;
      pos_q     <= '0;
      getp_q    <= 1'b1;
      headp_q   <= 1'b1;
      verdict_q <= VERDICT_NONE;
    end else begin
      blm_q     <= blm_d;
      hdone_q   <= hdone_d;
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      getp_q    <= getp_d;
      headp_q   <= headp_d;
      verdict_q <= verdict_d;
    end
  end

  assign res_o.valid         = advance_o && stage_i.item.last_byte;
  assign res_o.request_class = cls;
endmodule

### sv/hsrc_out_stage.sv
// Result register of the classifier: holds one class item until the sink takes it.
// Depends on hsrc_pkg.
module hsrc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsrc_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  output logic [1:0]        out_class_o
);
  import hsrc_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] class_q;

  assign out_free_o = !valid_q || out_ready_i;
  assign valid_d    = res_i.valid ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      class_q <= res_i.request_class;
    end
  end

  assign out_valid_o = valid_q;
  assign out_class_o = class_q;
endmodule

### sv/http_settings_request_classifier.sv
// Request classifier top level: input register, per-byte state update, result register.
// A byte accepted into the input register updates the matcher state at the edge that
// advances it, where the class item of a final byte is also loaded into the result
// register. Throughput: one byte per cycle; a waiting result stalls only a following final byte.
// Reset: rst_ni low clears both stage valids and all matcher state at once.
`include "http_settings_request_classifier_macros.svh"
module http_settings_request_classifier (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsrc_byte_if.sink    byte_i,
  hsrc_class_if.source class_o
);
  import hsrc_pkg::*;

  byte_item_t in_item;
  stage_t     stage;
  result_t    res;
  logic       advance;
  logic       out_free;

  assign in_item.data_byte = byte_i.data_byte;
  assign in_item.last_byte = byte_i.last_byte;

  hsrc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (byte_i.ready),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  hsrc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage),
    .out_free_i (out_free),
    .advance_o  (advance),
    .res_o      (res)
  );

  hsrc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_ready_i (class_o.ready),
    .out_free_o  (out_free),
    .out_valid_o (class_o.valid),
    .out_class_o (class_o.request_class)
  );

  `HSRC_ASSERT_IMPL(a_res_has_room, clk_i, rst_ni, res.valid, out_free)
  `HSRC_ASSERT_NEXT(a_stalled_final_held, clk_i, rst_ni,
                    stage.valid && stage.item.last_byte && !out_free, stage.valid)
  `HSRC_ASSERT_IMPL(a_out_from_final, clk_i, rst_ni, $rose(class_o.valid),
                    $past(stage.valid && stage.item.last_byte))
endmodule

### bench/hsrc_class_checker.sv
// Checker for the request classifier: watches the byte and class channels,
// predicts the class of every buffer and compares it with the class item seen.
// Depends on hsrc_pkg and the hsrc_byte_if / hsrc_class_if interfaces.
`timescale 1ns / 1ps
module hsrc_class_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  hsrc_byte_if  byte_mon,
  hsrc_class_if class_mon,
  output int    mismatch_count,
  output int    pending_count
);
  import hsrc_pkg::*;

  localparam logic [7:0] SETTINGS_PATH [0:8] = '{8'h2F, 8'h73, 8'h65, 8'h74, 8'h74,
                                                 8'h69, 8'h6E, 8'h67, 8'h73};
  localparam logic [7:0] GET_WORD [0:2]  = '{8'h47, 8'h45, 8'h54};
  localparam logic [7:0] HEAD_WORD [0:3] = '{8'h48, 8'h45, 8'h41, 8'h44};

  logic [1:0] crlf_progress;
  logic       headers_seen;
  logic [2:0] parse_phase;
  logic [3:0] token_idx;
  logic       may_be_get;
  logic       may_be_head;
  logic [1:0] line_class;

  logic [1:0] pending_classes[$];

  task automatic clear_parser();
    crlf_progress = BLM_NONE;
    headers_seen  = 1'b0;
    parse_phase   = PH_METHOD;
    token_idx     = '0;
    may_be_get    = 1'b1;
    may_be_head   = 1'b1;
    line_class    = VERDICT_NONE;
  endtask

  task automatic classify_byte(input logic [7:0] c, input logic last);
    logic [7:0] up;
    logic [1:0] cls;
    if (c == CH_CR) begin
      crlf_progress = (crlf_progress == BLM_CRLF) ? BLM_CRLFCR : BLM_CR;
    end else if (c == CH_LF) begin
      if (crlf_progress == BLM_CR) begin
        crlf_progress = BLM_CRLF;
      end else begin
        if (crlf_progress == BLM_CRLFCR) headers_seen = 1'b1;
        crlf_progress = BLM_NONE;
      end
    end else begin
      crlf_progress = BLM_NONE;
    end

    case (parse_phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          may_be_get  = may_be_get && (token_idx == GET_LEN);
          may_be_head = may_be_head && (token_idx == HEAD_LEN);
          if (!may_be_get && !may_be_head) begin
            line_class  = CLS_OTHER;
            parse_phase = PH_DONE;
          end else begin
            parse_phase = PH_PATH;
            token_idx   = '0;
          end
        end else if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
          line_class  = CLS_OTHER;
          parse_phase = PH_DONE;
        end else begin
          up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
          if (token_idx >= GET_LEN || up != GET_WORD[token_idx]) may_be_get = 1'b0;
          if (token_idx >= HEAD_LEN || up != HEAD_WORD[token_idx]) may_be_head = 1'b0;
          if (token_idx < POS_MAX) token_idx++;
        end
      end
      PH_PATH: begin
        if (token_idx < PATH_LEN) begin
          if (c == SETTINGS_PATH[token_idx]) begin
            token_idx++;
          end else begin
            line_class  = CLS_OTHER;
            parse_phase = PH_DONE;
          end
        end else begin
          if (c == CH_SP || c == CH_Q || c == CH_CR || c == CH_LF || c == CH_NUL) begin
            line_class = may_be_head ? CLS_HEAD : (may_be_get ? CLS_GET : CLS_OTHER);
          end else begin
            line_class = CLS_OTHER;
          end
          parse_phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (last) begin
      if (!headers_seen) cls = CLS_INCOMPLETE;
      else if (line_class == VERDICT_NONE) cls = CLS_OTHER;
      else cls = line_class;
      pending_classes.push_back(cls);
      clear_parser();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [1:0] want;
    if (!rst_ni) begin
      clear_parser();
      pending_classes.delete();
      mismatch_count = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        classify_byte(byte_mon.data_byte, byte_mon.last_byte);
      end
      if (class_mon.valid && class_mon.ready) begin
        if (pending_classes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("class item %0d arrived with no buffer pending", class_mon.request_class);
          end
        end else begin
          want = pending_classes.pop_front();
          if (class_mon.request_class !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("request_class expected %0d actual %0d", want,
                       class_mon.request_class);
            end
          end
        end
      end
    end
    pending_count = pending_classes.size();
  end

endmodule

### bench/tb_top.sv
// Top of the request classifier bench: clock, reset, byte stimulus and
// receiver stalls; the verdict comes from hsrc_class_checker.
// Depends on hsrc_pkg, both channel interfaces and the classifier RTL.
`timescale 1ns / 1ps
module tb_top;
  import hsrc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 260;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;
  int   cycle_count = 0;
  int   sent_bytes;
  int   mismatch_count;
  int   pending_count;

  logic [7:0] req_bytes[$];

  hsrc_byte_if  byte_bus ();
  hsrc_class_if class_bus ();

  http_settings_request_classifier DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_bus),
    .class_o (class_bus)
  );

  hsrc_class_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_mon       (byte_bus),
    .class_mon      (class_bus),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("http_settings_request_classifier: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    class_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: b = CH_CR;
        1: b = CH_LF;
        2: b = CH_SP;
        3: b = CH_NUL;
        default: b = CH_Q;
      endcase
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) return c + 8'h20;
    return c;
  endfunction

  task automatic add_text(input string s, input bit mixed);
    for (int i = 0; i < s.len(); i++) begin
      req_bytes.push_back(mixed ? mix_case(s[i]) : s[i]);
    end
  endtask

  task automatic add_crlf();
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(CH_LF);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic accepted;
    while ($urandom_range(0, 99) < idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    byte_bus.last_byte <= last;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = byte_bus.ready;
      @(posedge clk_i);
    end
  endtask

  task automatic send_request();
    for (int i = 0; i < req_bytes.size(); i++) begin
      send_byte(req_bytes[i], i == req_bytes.size() - 1);
    end
    sent_bytes += req_bytes.size();
    req_bytes.delete();
  endtask

  task automatic build_request();
    int n;
    int cut;
    int spot;
    int mode;
    string path;
    logic [7:0] ch;
    path = "/settings";
    req_bytes.delete();
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 10);
      repeat (n) req_bytes.push_back(any_byte());
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: add_text("GET", 1'b1);
      3, 4, 5: add_text("HEAD", 1'b1);
      6: begin
        n = $urandom_range(1, 5);
        repeat (n) req_bytes.push_back(mix_case(8'($urandom_range(8'h41, 8'h5A))));
      end
      7: begin
        n = $urandom_range(14, 19);
        repeat (n) req_bytes.push_back(mix_case(8'($urandom_range(8'h41, 8'h5A))));
      end
      8: begin
        case ($urandom_range(0, 4))
          0: add_text("GE", 1'b1);
          1: add_text("HEA", 1'b1);
          2: add_text("GETX", 1'b1);
          3: add_text("HEADS", 1'b1);
          default: add_text("POST", 1'b0);
        endcase
      end
      default: begin
        n = $urandom_range(0, 3);
        repeat (n) req_bytes.push_back(any_byte());
      end
    endcase
    req_bytes.push_back(($urandom_range(0, 99) < 85) ? CH_SP : any_byte());
    cut  = 9;
    spot = 99;
    mode = ($urandom_range(0, 99) < 75) ? 0 : $urandom_range(1, 3);
    if (mode == 3) cut = $urandom_range(0, 8);
    else if (mode != 0) spot = $urandom_range(0, 8);
    for (int i = 0; i < cut; i++) begin
      ch = path[i];
      if (i == spot) ch = (mode == 1) ? any_byte() : ch - 8'h20;
      req_bytes.push_back(ch);
    end
    if ($urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 4))
        0: ch = CH_SP;
        1: ch = CH_Q;
        2: ch = CH_CR;
        3: ch = CH_LF;
        default: ch = CH_NUL;
      endcase
    end else begin
      ch = any_byte();
    end
    req_bytes.push_back(ch);
    if (ch == CH_Q) add_text("a=1 HTTP/1.1", 1'b0);
    else if (ch == CH_SP) add_text("HTTP/1.1", 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      add_crlf();
      add_text("Host: x", 1'b0);
    end
    case ($urandom_range(0, 19))
      0, 1: begin
        add_crlf();
        req_bytes.push_back(CH_CR);
      end
      2, 3, 4: begin
      end
      default: begin
        add_crlf();
        add_crlf();
      end
    endcase
    if ($urandom_range(0, 99) < 30) begin
      n = $urandom_range(1, 5);
      repeat (n) req_bytes.push_back(any_byte());
    end
  endtask

  task automatic run_phase(input int sender_idle, input int receiver_stall);
    int target;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    target    = sent_bytes + PHASE_BYTES;
    while (sent_bytes < target) begin
      build_request();
      send_request();
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    byte_bus.valid     <= 1'b0;
    byte_bus.data_byte <= '0;
    byte_bus.last_byte <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    sent_bytes = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    req_bytes.push_back(8'hFF);
    send_request();
    req_bytes.push_back(CH_NUL);
    send_request();
    add_crlf();
    add_crlf();
    send_request();
    add_text("GET /settings", 1'b0);
    add_crlf();
    add_crlf();
    send_request();

    run_phase(0, 0);
    run_phase(77, 0);
    run_phase(0, 77);
    run_phase(19, 19);

    byte_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("http_settings_request_classifier: match");
    end else begin
      $display("http_settings_request_classifier: mismatch");
    end
    $finish;
  end

endmodule
